// ----- hw/rtl/utcl_pkg.sv -----
package utcl_pkg;

   localparam int unsigned DaysWidth  = 17;
   localparam int unsigned ClockWidth = 17;
   localparam int unsigned EpochWidth = 32;

   localparam logic [11:0] CenturyBase   = 12'd2000;
   localparam logic [19:0] EpochDayBias  = 20'd719499;
   localparam logic [16:0] SecsPerDay    = 17'd86400;
   localparam logic [11:0] SecsPerHour   = 12'd3600;
   localparam logic [8:0]  DaysPerYear   = 9'd365;
   localparam logic [10:0] DaysPerQuad   = 11'd1461;
   localparam logic [16:0] DaysTo2000    = 17'd10957;

   // Configuration register indexes.
   localparam logic CsrZoneHours = 1'b0;
   localparam logic CsrZoneWest  = 1'b1;

   // One converted request on its way from the front part to the back part.
   typedef struct packed {
      logic [DaysWidth-1:0]  local_days;
      logic [ClockWidth-1:0] local_clock;
      logic [EpochWidth-1:0] epoch;
   } item_type;

   // Floor of 367 * m / 12 for the shifted month m.
   function automatic logic [8:0] month_term(input logic [3:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd30;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd91;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd152;
         4'd6:    r = 9'd183;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd244;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd305;
         4'd11:   r = 9'd336;
         4'd12:   r = 9'd367;
         4'd13:   r = 9'd397;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Days before the first of month index k (0 is January).
   function automatic logic [8:0] cum_days(input logic lp, input logic [3:0] k);
      logic [8:0] r;
      case (k)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         default: r = 9'd365;
      endcase
      if (lp && k >= 4'd2) begin
         r = r + 9'd1;
      end
      return r;
   endfunction

   // Gregorian leap rule, exact from 1970 to 2200, which covers the years this block can reach.
   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != 12'd2100) && (y != 12'd2200);
   endfunction

endpackage

// ----- hw/rtl/utcl_front.sv -----
module utcl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [6:0]            year_two_digit,
   input  logic [3:0]            month_in,
   input  logic [4:0]            day_in,
   input  logic [4:0]            hour_in,
   input  logic [5:0]            minute_in,
   input  logic [5:0]            second_in,
   input  logic [3:0]            zone_hours,
   input  logic                  zone_west,
   output logic                  occupied,
   output logic                  push,
   output utcl_pkg::item_type    push_item
);

   logic                              s1_valid_ff;
   logic                              s2_valid_ff;
   logic [utcl_pkg::DaysWidth-1:0]    days_ff, days_in;
   logic [utcl_pkg::ClockWidth-1:0]   tod_ff, tod_in;

   logic [11:0] y_c;
   logic [3:0]  m_c;
   logic [19:0] y_w;
   logic [19:0] c100;
   logic [19:0] c400;
   logic [19:0] sum_c;

   always_comb begin
      if (month_in <= 4'd2) begin
         m_c = month_in + 4'd10;
         y_c = utcl_pkg::CenturyBase + 12'(year_two_digit) - 12'd1;
      end else begin
         m_c = month_in - 4'd2;
         y_c = utcl_pkg::CenturyBase + 12'(year_two_digit);
      end
      y_w  = 20'(y_c);
      // Years span 1999 to 2127, so the century counts take only a few values.
      c100 = (y_c < 12'd2000) ? 20'd19 : ((y_c < 12'd2100) ? 20'd20 : 20'd21);
      c400 = (y_c < 12'd2000) ? 20'd4 : 20'd5;
      sum_c = y_w * 20'(utcl_pkg::DaysPerYear) + (y_w >> 2) - c100 + c400
            + 20'(utcl_pkg::month_term(m_c)) + 20'(day_in) - utcl_pkg::EpochDayBias;
      days_in = sum_c[utcl_pkg::DaysWidth-1:0];
      tod_in  = 17'(hour_in) * 17'(utcl_pkg::SecsPerHour) + 17'(minute_in) * 17'd60
              + 17'(second_in);
   end

   logic [33:0]        secs_c;
   logic [15:0]        off_c;
   logic signed [18:0] tods_c;

   always_comb begin
      secs_c = 34'(days_ff) * 34'(utcl_pkg::SecsPerDay) + 34'(tod_ff);
      off_c  = 16'(zone_hours) * 16'(utcl_pkg::SecsPerHour);
      if (zone_west) begin
         tods_c = signed'(19'(tod_ff)) - signed'(19'(off_c));
      end else begin
         tods_c = signed'(19'(tod_ff)) + signed'(19'(off_c));
      end
      push_item.epoch = secs_c[utcl_pkg::EpochWidth-1:0];
      // The time of day plus the offset lies within one day either side.
      if (tods_c < 0) begin
         push_item.local_days  = days_ff - 17'd1;
         push_item.local_clock = 17'(tods_c + signed'(19'(utcl_pkg::SecsPerDay)));
      end else if (tods_c >= signed'(19'(utcl_pkg::SecsPerDay))) begin
         push_item.local_days  = days_ff + 17'd1;
         push_item.local_clock = 17'(tods_c - signed'(19'(utcl_pkg::SecsPerDay)));
      end else begin
         push_item.local_days  = days_ff;
         push_item.local_clock = 17'(tods_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      if (accept) begin
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
   end

   assign occupied = s1_valid_ff | s2_valid_ff;
   assign push     = s2_valid_ff;

endmodule

// ----- hw/rtl/utcl_queue.sv -----
module utcl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  utcl_pkg::item_type    push_item,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output utcl_pkg::item_type    head
);

   utcl_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);

endmodule

// ----- hw/rtl/utcl_back.sv -----
module utcl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  utcl_pkg::item_type    q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output logic [11:0]           rsp_local_year,
   output logic [3:0]            rsp_local_month,
   output logic [4:0]            rsp_local_day,
   output logic [4:0]            rsp_local_hour,
   output logic [5:0]            rsp_local_minute,
   output logic [5:0]            rsp_local_second,
   output logic [31:0]           rsp_utc_epoch_seconds
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_YEAR, ST_MONTH, ST_REM, ST_MIN, ST_OUT
   } state_type;

   state_type                         state_ff;
   logic [11:0]                       yr_ff;
   logic [utcl_pkg::DaysWidth-1:0]    rem_ff;
   logic [utcl_pkg::ClockWidth-1:0]   clk_ff;
   logic [31:0]                       epoch_ff;
   logic [3:0]                        mon_ff;
   logic [4:0]                        day_ff;
   logic [4:0]                        hour_ff;
   logic [11:0]                       rsec_ff;
   logic [5:0]                        min_ff;
   logic                              valid_ff;
   logic [11:0]                       year_out_ff;
   logic [3:0]                        mon_out_ff;
   logic [4:0]                        day_out_ff;
   logic [4:0]                        hour_out_ff;
   logic [5:0]                        min_out_ff;
   logic [5:0]                        sec_out_ff;
   logic [31:0]                       epoch_out_ff;

   logic        lp_c;
   logic [8:0]  ylen_c;
   logic [3:0]  mo_c;
   logic [33:0] hprod_c;
   logic [24:0] mprod_c;

   always_comb begin
      lp_c   = utcl_pkg::is_leap(yr_ff);
      ylen_c = utcl_pkg::DaysPerYear + 9'(lp_c);
      mo_c   = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (rem_ff >= 17'(utcl_pkg::cum_days(lp_c, 4'(k)))) begin
            mo_c = 4'(k);
         end
      end
      // Reciprocal multiplies, exact over a day and over an hour.
      hprod_c = 34'(clk_ff) * 34'd37283;
      mprod_c = 25'(rsec_ff) * 25'd4370;
   end

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (state_ff == ST_OUT);
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_item.local_days >= utcl_pkg::DaysTo2000) begin
                     yr_ff  <= 12'd2000;
                     rem_ff <= q_item.local_days - utcl_pkg::DaysTo2000;
                  end else begin
                     yr_ff  <= 12'd1970;
                     rem_ff <= q_item.local_days;
                  end
                  clk_ff   <= q_item.local_clock;
                  epoch_ff <= q_item.epoch;
                  state_ff <= ST_YEAR;
               end
            end
            ST_YEAR: begin
               // Inside 2000 to 2099 a four-year block always holds 1461 days.
               if (yr_ff >= 12'd2000 && yr_ff <= 12'd2096 && yr_ff[1:0] == 2'b00 &&
                   rem_ff >= 17'(utcl_pkg::DaysPerQuad)) begin
                  rem_ff <= rem_ff - 17'(utcl_pkg::DaysPerQuad);
                  yr_ff  <= yr_ff + 12'd4;
               end else if (rem_ff >= 17'(ylen_c)) begin
                  rem_ff <= rem_ff - 17'(ylen_c);
                  yr_ff  <= yr_ff + 12'd1;
               end else begin
                  state_ff <= ST_MONTH;
               end
            end
            ST_MONTH: begin
               mon_ff   <= mo_c + 4'd1;
               day_ff   <= 5'(rem_ff - 17'(utcl_pkg::cum_days(lp_c, mo_c)) + 17'd1);
               hour_ff  <= 5'(hprod_c >> 27);
               state_ff <= ST_REM;
            end
            ST_REM: begin
               rsec_ff  <= 12'(clk_ff - 17'(hour_ff) * 17'(utcl_pkg::SecsPerHour));
               state_ff <= ST_MIN;
            end
            ST_MIN: begin
               min_ff   <= 6'(mprod_c >> 18);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               year_out_ff  <= yr_ff;
               mon_out_ff   <= mon_ff;
               day_out_ff   <= day_ff;
               hour_out_ff  <= hour_ff;
               min_out_ff   <= min_ff;
               sec_out_ff   <= 6'(rsec_ff - 12'(min_ff) * 12'd60);
               epoch_out_ff <= epoch_ff;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_local_year        = year_out_ff;
   assign rsp_local_month       = mon_out_ff;
   assign rsp_local_day         = day_out_ff;
   assign rsp_local_hour        = hour_out_ff;
   assign rsp_local_minute      = min_out_ff;
   assign rsp_local_second      = sec_out_ff;
   assign rsp_utc_epoch_seconds = epoch_out_ff;

endmodule

// ----- hw/rtl/utc_to_local_datetime.sv -----
// The year search of the back part steps four years at a time inside 2000 to 2099
// and one year elsewhere, so the time a request takes depends on its date.
// Throughput: one request per conversion, set by the year search of the back part;
// a two-entry queue lets the front take the next request while the back works.
// Results appear for one cycle on rsp_valid; the receiver cannot stall them.
// Reset is synchronous and active high; it sets zone_hours to 8 and zone_west to 0.
module utc_to_local_datetime (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [6:0]  req_year_two_digit,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   output logic        rsp_valid,
   output logic [11:0] rsp_local_year,
   output logic [3:0]  rsp_local_month,
   output logic [4:0]  rsp_local_day,
   output logic [4:0]  rsp_local_hour,
   output logic [5:0]  rsp_local_minute,
   output logic [5:0]  rsp_local_second,
   output logic [31:0] rsp_utc_epoch_seconds,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   logic [3:0] zone_hours_ff;
   logic       zone_west_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_hours_ff <= 4'd8;
         zone_west_ff  <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == utcl_pkg::CsrZoneHours) begin
            zone_hours_ff <= csr_wdata;
         end else begin
            zone_west_ff <= csr_wdata[0];
         end
      end
   end

   logic               occupied;
   logic               push;
   utcl_pkg::item_type push_item;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   utcl_pkg::item_type q_item;
   logic               accept;

   assign busy   = occupied | q_full;
   assign accept = start & ~busy;

   utcl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .year_two_digit (req_year_two_digit),
      .month_in       (req_month_in),
      .day_in         (req_day_in),
      .hour_in        (req_hour_in),
      .minute_in      (req_minute_in),
      .second_in      (req_second_in),
      .zone_hours     (zone_hours_ff),
      .zone_west      (zone_west_ff),
      .occupied       (occupied),
      .push           (push),
      .push_item      (push_item)
   );

   utcl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_item)
   );

   utcl_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .q_item                (q_item),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_local_year        (rsp_local_year),
      .rsp_local_month       (rsp_local_month),
      .rsp_local_day         (rsp_local_day),
      .rsp_local_hour        (rsp_local_hour),
      .rsp_local_minute      (rsp_local_minute),
      .rsp_local_second      (rsp_local_second),
      .rsp_utc_epoch_seconds (rsp_utc_epoch_seconds)
   );

endmodule
